// ----- design/jdm_pkg.sv -----
// Shared types, codes and constants of the joystick drive mixer.
package jdm_pkg;

	localparam int ADC_FULL_SCALE_DEF = 1023;
	localparam int DIV_W = 20;

	localparam logic [8:0] DEAD_BAND_RST  = 9'd20;
	localparam logic [7:0] LEFT_TRIM_RST  = 8'hF9;
	localparam logic [7:0] RIGHT_TRIM_RST = 8'h00;
	localparam logic [7:0] SLIDE_MAX_RST  = 8'd16;
	localparam logic [7:0] SLIDE_MIN_RST  = 8'd1;

	localparam logic [2:0] REG_DEAD_BAND  = 3'd0;
	localparam logic [2:0] REG_LEFT_TRIM  = 3'd1;
	localparam logic [2:0] REG_RIGHT_TRIM = 3'd2;
	localparam logic [2:0] REG_SLIDE_MAX  = 3'd3;
	localparam logic [2:0] REG_SLIDE_MIN  = 3'd4;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PLAN  = 6'b000010,
		ST_DIV1  = 6'b000100,
		ST_DIV2  = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic plan;
		logic start1;
		logic start2;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_div2;
	} status_t;

endpackage

// ----- design/joystick_drive_mixer.sv -----
// Top level of the joystick drive mixer.
// Input channel: in_valid/in_ready carry one joystick packet per item.
// Output channel: out_valid/out_ready carry the full command set per item.
// Configuration: cfg_we with cfg_index 0..4 (dead band, left trim, right trim,
// slide maximum, slide minimum) writes a register; write only while the block
// is idle.
// An item takes one or two passes through a shared 20-bit restoring divider,
// one quotient bit per cycle. Spins, stops, straight reverse moves and arm
// items need one division; veers and straight forward moves need a second.
// One item is in flight at a time; the next item is accepted in the cycle
// after the previous result has been taken.
// If the receiver stalls, the result is held on the outputs and input
// acceptance waits.
// Reset clears all commands and restores the register reset values.
module joystick_drive_mixer #(
	parameter int ADC_FULL_SCALE = jdm_pkg::ADC_FULL_SCALE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       stick_id,
	input  logic [9:0] stick_x,
	input  logic [9:0] stick_y,
	input  logic [9:0] centre_x,
	input  logic [9:0] centre_y,
	input  logic       button_down,
	input  logic [7:0] slide_position,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] left_dir,
	output logic [1:0] right_dir,
	output logic [7:0] left_duty,
	output logic [7:0] right_duty,
	output logic [1:0] slide_cmd,
	output logic [1:0] lift_cmd,
	output logic       headlight_on,
	output logic       rotisserie_on
);
	jdm_pkg::cmd_t    cmd;
	jdm_pkg::status_t status;

	jdm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
	);

	jdm_datapath #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.stick_id(stick_id), .stick_x(stick_x), .stick_y(stick_y),
		.centre_x(centre_x), .centre_y(centre_y), .button_down(button_down),
		.slide_position(slide_position),
		.left_dir(left_dir), .right_dir(right_dir), .left_duty(left_duty),
		.right_duty(right_duty), .slide_cmd(slide_cmd), .lift_cmd(lift_cmd),
		.headlight_on(headlight_on), .rotisserie_on(rotisserie_on)
	);
endmodule

// ----- design/jdm_divider.sv -----
// Restoring divider for non-negative operands, one quotient bit per cycle.
module jdm_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [jdm_pkg::DIV_W-1:0] dividend,
	input  logic [jdm_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [jdm_pkg::DIV_W-1:0] quotient
);
	localparam int CW = $clog2(jdm_pkg::DIV_W + 1);

	logic [jdm_pkg::DIV_W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic [jdm_pkg::DIV_W:0]   trial;

	assign trial = {rem_q, quo_q[jdm_pkg::DIV_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(jdm_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[jdm_pkg::DIV_W]) begin
				rem_q <= trial[jdm_pkg::DIV_W-1:0];
				quo_q <= {quo_q[jdm_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[jdm_pkg::DIV_W-2:0], quo_q[jdm_pkg::DIV_W-1]};
				quo_q <= {quo_q[jdm_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ----- design/jdm_datapath.sv -----
// Datapath: decision logic, map-rule operands, trim saturation and command registers.
module jdm_datapath #(
	parameter int ADC_FULL_SCALE = jdm_pkg::ADC_FULL_SCALE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jdm_pkg::cmd_t        cmd,
	output jdm_pkg::status_t     status,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	input  logic                 stick_id,
	input  logic [9:0]           stick_x,
	input  logic [9:0]           stick_y,
	input  logic [9:0]           centre_x,
	input  logic [9:0]           centre_y,
	input  logic                 button_down,
	input  logic [7:0]           slide_position,
	output logic [1:0]           left_dir,
	output logic [1:0]           right_dir,
	output logic [7:0]           left_duty,
	output logic [7:0]           right_duty,
	output logic [1:0]           slide_cmd,
	output logic [1:0]           lift_cmd,
	output logic                 headlight_on,
	output logic                 rotisserie_on
);
	localparam int W = jdm_pkg::DIV_W;
	localparam logic signed [13:0] FS = 14'(ADC_FULL_SCALE);

	typedef enum logic [2:0] {
		K_SPIN_CW = 3'd0, K_SPIN_CCW = 3'd1, K_STRAIGHT = 3'd2,
		K_VEER_R = 3'd3, K_VEER_L = 3'd4, K_STOP = 3'd5, K_ARM = 3'd6
	} kind_t;

	logic [8:0]  dead_band_q;
	logic [7:0]  left_trim_q, right_trim_q, slide_max_q, slide_min_q;
	logic        id_q, btn_q;
	logic [9:0]  x_q, y_q, cx_q, cy_q;
	logic [7:0]  pos_q;
	kind_t       kind_q;
	logic        fwd_q;
	logic [8:0]  base_q;
	logic        div1_zero_q, div2_zero_q;

	// Division operands: all map-rule numerators here are non-negative.
	logic [W-1:0] num1, den1, num2, den2, dnum, dden, quo;
	logic         dstart, ddone;
	logic [W-1:0] q1_eff;
	logic [8:0]   base_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q  <= jdm_pkg::DEAD_BAND_RST;
			left_trim_q  <= jdm_pkg::LEFT_TRIM_RST;
			right_trim_q <= jdm_pkg::RIGHT_TRIM_RST;
			slide_max_q  <= jdm_pkg::SLIDE_MAX_RST;
			slide_min_q  <= jdm_pkg::SLIDE_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				jdm_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg_data;
				jdm_pkg::REG_LEFT_TRIM:  left_trim_q  <= cfg_data[7:0];
				jdm_pkg::REG_RIGHT_TRIM: right_trim_q <= cfg_data[7:0];
				jdm_pkg::REG_SLIDE_MAX:  slide_max_q  <= cfg_data[7:0];
				jdm_pkg::REG_SLIDE_MIN:  slide_min_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= stick_id; btn_q <= button_down;
			x_q <= stick_x; y_q <= stick_y; cx_q <= centre_x; cy_q <= centre_y;
			pos_q <= slide_position;
		end
	end

	// Decision on the captured packet.
	logic signed [12:0] x, y, cx, cy, m, dx, dy, ady;
	kind_t kind_d;
	logic  fwd_d;
	always_comb begin
		x = 13'(x_q); y = 13'(y_q); cx = 13'(cx_q); cy = 13'(cy_q);
		m = 13'(dead_band_q);
		dx = x - cx; dy = y - cy;
		ady = dy[12] ? -dy : dy;
		fwd_d = y > cy + m;
		if (id_q)
			kind_d = K_ARM;
		else if (x > cx + m && ady < m)
			kind_d = K_SPIN_CW;
		else if (x < cx - m && ady < m)
			kind_d = K_SPIN_CCW;
		else if (fwd_d || y < cy - m) begin
			if (dx > m)       kind_d = K_VEER_R;
			else if (dx < -m) kind_d = K_VEER_L;
			else              kind_d = K_STRAIGHT;
		end else
			kind_d = K_STOP;
	end

	// First division: base speed. Falling maps divide the reading and subtract from 255.
	always_comb begin
		logic signed [13:0] d;
		d = '0;
		num1 = '0; den1 = '0;
		case (kind_q)
			K_SPIN_CW: begin
				d = FS - 14'(cx_q);
				num1 = W'(({4'd0, x_q} - {4'd0, cx_q}) * 14'd255);
			end
			K_SPIN_CCW: begin
				d = 14'(cx_q);
				num1 = W'(14'(x_q) * 14'd255);
			end
			default: begin
				if (fwd_q) begin
					d = FS - 14'(cy_q);
					num1 = W'(({4'd0, y_q} - {4'd0, cy_q}) * 14'd255);
				end else begin
					d = 14'(cy_q);
					num1 = W'(14'(y_q) * 14'd255);
				end
			end
		endcase
		den1 = W'(d);
	end

	// Second division: the drop of the veer wheel below base, or straight forward at 512 scale.
	always_comb begin
		logic [13:0] d;
		d = '0;
		num2 = '0;
		case (kind_q)
			K_VEER_R: begin
				d = 14'(FS) - 14'(cx_q);
				num2 = W'((14'(x_q) - 14'(cx_q)) * 14'(base_d));
			end
			K_VEER_L: begin
				d = 14'(cx_q);
				num2 = W'((14'(cx_q) - 14'(x_q)) * 14'(base_d));
			end
			default: begin
				d = 14'(FS) - 14'(cy_q);
				num2 = W'((14'(y_q) - 14'(cy_q)) * 14'd512);
			end
		endcase
		den2 = W'(d);
	end

	// The divider holds the first quotient until the second division starts.
	always_comb begin
		q1_eff = div1_zero_q ? '0 : quo;
		case (kind_q)
			K_SPIN_CCW: base_d = 9'd255 - 9'(q1_eff > W'(255) ? W'(255) : q1_eff);
			K_STRAIGHT, K_VEER_R, K_VEER_L:
				base_d = fwd_q ? (q1_eff > W'(255) ? 9'd255 : 9'(q1_eff))
				               : 9'd255 - 9'(q1_eff > W'(255) ? W'(255) : q1_eff);
			default: base_d = q1_eff > W'(255) ? 9'd255 : 9'(q1_eff);
		endcase
	end

	assign dstart = cmd.start1 | cmd.start2;
	assign dnum   = cmd.start1 ? num1 : num2;
	assign dden   = cmd.start1 ? den1 : den2;

	jdm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(dnum), .divisor(dden), .done(ddone), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			kind_q <= kind_d;
			fwd_q  <= fwd_d;
		end
		if (cmd.start1) div1_zero_q <= (den1 == '0);
		if (cmd.start2) div2_zero_q <= (den2 == '0);
		if (cmd.start2) base_q <= base_d;
	end

	assign status.div_done  = ddone;
	assign status.need_div2 = (kind_q == K_VEER_R || kind_q == K_VEER_L ||
	                           (kind_q == K_STRAIGHT && fwd_q));

	function automatic logic [7:0] sat(input logic signed [10:0] v);
		if (v < 0) return 8'd0;
		if (v > 11'sd255) return 8'd255;
		return v[7:0];
	endfunction

	// Final speeds at apply; the second quotient is read straight from the divider.
	logic [8:0] s2, base_a, l_spd, r_spd;
	logic [W-1:0] q2_eff;
	always_comb begin
		q2_eff = div2_zero_q ? '0 : quo;
		base_a = status.need_div2 ? base_q : base_d;
		case (kind_q)
			K_VEER_R, K_VEER_L: s2 = base_a - 9'(q2_eff);
			default: s2 = q2_eff > W'(255) ? 9'd255 : 9'(q2_eff);
		endcase
		l_spd = base_a; r_spd = base_a;
		case (kind_q)
			K_VEER_R: r_spd = s2;
			K_VEER_L: l_spd = s2;
			K_STRAIGHT: if (fwd_q) begin l_spd = s2; r_spd = s2; end
			K_STOP: begin l_spd = '0; r_spd = '0; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dir <= jdm_pkg::DIR_STOP; right_dir <= jdm_pkg::DIR_STOP;
			left_duty <= '0; right_duty <= '0;
			slide_cmd <= jdm_pkg::DIR_STOP; lift_cmd <= jdm_pkg::DIR_STOP;
			headlight_on <= 1'b0; rotisserie_on <= 1'b0;
		end else if (cmd.apply) begin
			if (btn_q) begin
				if (id_q) rotisserie_on <= ~rotisserie_on;
				else      headlight_on  <= ~headlight_on;
			end
			case (kind_q)
				K_SPIN_CW: begin left_dir <= jdm_pkg::DIR_FWD; right_dir <= jdm_pkg::DIR_BACK; end
				K_SPIN_CCW: begin left_dir <= jdm_pkg::DIR_BACK; right_dir <= jdm_pkg::DIR_FWD; end
				K_STRAIGHT, K_VEER_R, K_VEER_L: begin
					left_dir  <= fwd_q ? jdm_pkg::DIR_FWD : jdm_pkg::DIR_BACK;
					right_dir <= fwd_q ? jdm_pkg::DIR_FWD : jdm_pkg::DIR_BACK;
				end
				default: ;
			endcase
			if (kind_q != K_ARM) begin
				left_duty  <= sat(11'(l_spd) + 11'($signed(left_trim_q)));
				right_duty <= sat(11'(r_spd) + 11'($signed(right_trim_q)));
			end
			if (kind_q == K_STOP) begin
				left_dir <= jdm_pkg::DIR_STOP; right_dir <= jdm_pkg::DIR_STOP;
				slide_cmd <= jdm_pkg::DIR_STOP; lift_cmd <= jdm_pkg::DIR_STOP;
			end
			if (kind_q == K_ARM) begin
				if (y > cy + m) begin
					if (pos_q < slide_max_q) slide_cmd <= jdm_pkg::DIR_FWD;
				end else if (y < cy - m) begin
					if (pos_q > slide_min_q) slide_cmd <= jdm_pkg::DIR_BACK;
				end else if (x > cx + m) lift_cmd <= jdm_pkg::DIR_BACK;
				else if (x < cx - m) lift_cmd <= jdm_pkg::DIR_FWD;
				else begin
					left_dir <= jdm_pkg::DIR_STOP; right_dir <= jdm_pkg::DIR_STOP;
					slide_cmd <= jdm_pkg::DIR_STOP; lift_cmd <= jdm_pkg::DIR_STOP;
					left_duty  <= sat(11'($signed(left_trim_q)));
					right_duty <= sat(11'($signed(right_trim_q)));
				end
			end
		end
	end
endmodule

// ----- design/jdm_ctrl.sv -----
// Controller state machine sequencing one item through the datapath.
module jdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output jdm_pkg::cmd_t     cmd,
	input  jdm_pkg::status_t  status
);
	jdm_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			jdm_pkg::ST_IDLE: if (in_valid) begin
				cmd.load = 1'b1; state_d = jdm_pkg::ST_PLAN;
			end
			jdm_pkg::ST_PLAN: begin
				cmd.plan = 1'b1; state_d = jdm_pkg::ST_DIV1;
			end
			jdm_pkg::ST_DIV1: begin
				cmd.start1 = 1'b1; state_d = jdm_pkg::ST_DIV2;
			end
			jdm_pkg::ST_DIV2: if (status.div_done) begin
				if (status.need_div2) begin
					cmd.start2 = 1'b1; state_d = jdm_pkg::ST_APPLY;
				end else begin
					cmd.apply = 1'b1; state_d = jdm_pkg::ST_OUT;
				end
			end
			jdm_pkg::ST_APPLY: if (status.div_done) begin
				cmd.apply = 1'b1; state_d = jdm_pkg::ST_OUT;
			end
			jdm_pkg::ST_OUT: if (out_ready) state_d = jdm_pkg::ST_IDLE;
			default: state_d = jdm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= jdm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	assign in_ready  = (state_q == jdm_pkg::ST_IDLE);
	assign out_valid = (state_q == jdm_pkg::ST_OUT);

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_apply_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid) else $error("apply not followed by result");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");
`endif
endmodule
